FILE: hdl/nll_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nonlinear ladder lowpass package
// Shared widths, fixed-point constants, register codes and the handoff
// structure that links neighboring ladder cells.
// ----------------------------------------------------------------------------
package nll_pkg;

    // Default sample width on the stream ports.
    localparam int SAMPLE_BITS_DEF = 24;

    // Internal fixed point: stage states are Q1.22.
    localparam int FRAC       = 22;
    localparam int STAGE_W    = 24;
    localparam int NUM_STAGES = 4;

    // Drive term handed into a cell, Q.22 scale.
    localparam int DRIVE_W = 32;

    // Cubic soft clip: argument saturated to +-4, result width.
    localparam int ARG_W      = 26;
    localparam int CUBE_OUT_W = 30;
    localparam int CUBE_LAT   = 3;

    // Configuration register widths.
    localparam int GAIN_W    = 17;
    localparam int RES_W     = 16;
    localparam int DRV_AMT_W = 16;

    // Shifts of the two front products and of the stage step.
    localparam int PRE_SHIFT  = 12;
    localparam int GAIN_FRAC  = 16;
    localparam int DRIVE_BASE = 8192;

    // APB port.
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    // Register indexes, taken from paddr[3:2].
    localparam logic [1:0] REG_CUTOFF    = 2'd0;
    localparam logic [1:0] REG_RESONANCE = 2'd1;
    localparam logic [1:0] REG_DRIVE     = 2'd2;

    // Register reset values and step limits.
    localparam logic [GAIN_W-1:0]    CUTOFF_RESET    = 17'd4295;
    localparam logic [RES_W-1:0]     RESONANCE_RESET = 16'd8192;
    localparam logic [DRV_AMT_W-1:0] DRIVE_RESET     = 16'd4096;
    localparam logic [GAIN_W-1:0]    GAIN_MIN        = 17'd7;
    localparam logic [GAIN_W-1:0]    GAIN_MAX        = 17'd65536;

    // Stage state limits, +-1.0 in Q1.22.
    localparam logic signed [STAGE_W-1:0] STAGE_ONE     = 24'sd4194304;
    localparam logic signed [STAGE_W-1:0] STAGE_NEG_ONE = -24'sd4194304;

    // Handoff from one cell to the next: a start pulse and the drive term.
    typedef struct packed {
        logic                       go;
        logic signed [DRIVE_W-1:0]  drive;
    } nll_link_t;

endpackage

FILE: hdl/nll_cubic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cubic soft clip
// Three-stage pipeline computing (3a - a^3) / 2 on a Q.22 argument that is
// already saturated to +-4. Every right shift rounds half up.
// ----------------------------------------------------------------------------
module nll_cubic (
    input  logic                                   clk,
    input  logic signed [nll_pkg::ARG_W-1:0]       arg,
    output logic signed [nll_pkg::CUBE_OUT_W-1:0]  clip
);
    import nll_pkg::*;

    localparam int SQ_W = 2 * ARG_W;
    localparam int A2_W = ARG_W + 2;
    localparam int CB_W = A2_W + ARG_W;
    localparam int T_W  = CUBE_OUT_W + 1;

    localparam logic signed [SQ_W-1:0] SQ_HALF = SQ_W'(1) <<< (FRAC - 1);
    localparam logic signed [CB_W-1:0] CB_HALF = CB_W'(1) <<< (FRAC - 1);

    logic signed [SQ_W-1:0]       sq;
    logic signed [SQ_W-1:0]       sq_rnd;
    logic signed [SQ_W-1:0]       sq_shr;
    logic signed [CB_W-1:0]       cb;
    logic signed [CB_W-1:0]       cb_rnd;
    logic signed [CB_W-1:0]       cb_shr;
    logic signed [T_W-1:0]        t_arg;
    logic signed [T_W-1:0]        t_sum;
    logic signed [T_W-1:0]        t_rnd;
    logic signed [T_W-1:0]        t_shr;
    logic signed [A2_W-1:0]       a2_reg;
    logic signed [ARG_W-1:0]      arg1_reg;
    logic signed [CUBE_OUT_W-1:0] a3_reg;
    logic signed [ARG_W-1:0]      arg2_reg;
    logic signed [CUBE_OUT_W-1:0] clip_reg;

    // Stage one: square of the argument.
    assign sq     = arg * arg;
    assign sq_rnd = sq + SQ_HALF;
    assign sq_shr = sq_rnd >>> FRAC;

    // Stage two: cube from the registered square.
    assign cb     = a2_reg * arg1_reg;
    assign cb_rnd = cb + CB_HALF;
    assign cb_shr = cb_rnd >>> FRAC;

    // Stage three: 3a - a^3, halved.
    assign t_arg = T_W'(arg2_reg);
    assign t_sum = (t_arg <<< 1) + t_arg - T_W'(a3_reg);
    assign t_rnd = t_sum + T_W'(1);
    assign t_shr = t_rnd >>> 1;

    always_ff @(posedge clk)
    begin
        a2_reg   <= sq_shr[A2_W-1:0];
        arg1_reg <= arg;
        a3_reg   <= cb_shr[CUBE_OUT_W-1:0];
        arg2_reg <= arg1_reg;
        clip_reg <= t_shr[CUBE_OUT_W-1:0];
    end

    assign clip = clip_reg;

endmodule

FILE: hdl/nll_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ladder cell
// Holds one stage state. On a start pulse it forms the half difference of
// the drive term and its state, soft clips it, steps its state toward the
// clipped value by the gain and hands twice the new state to its neighbor.
// ----------------------------------------------------------------------------
module nll_cell (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic [nll_pkg::GAIN_W-1:0]           gain,
    input  nll_pkg::nll_link_t                   link_in,
    output nll_pkg::nll_link_t                   link_out,
    output logic signed [nll_pkg::STAGE_W-1:0]   stage
);
    import nll_pkg::*;

    localparam int DIFF_W = DRIVE_W + 1;
    localparam int PIPE_W = CUBE_LAT + 2;
    localparam int PD_W   = CUBE_OUT_W + 1;
    localparam int PROD_W = PD_W + GAIN_W + 1;
    localparam int SUM_W  = STAGE_W + 10;

    localparam logic signed [DIFF_W-1:0] ARG_MAX   = DIFF_W'(4) <<< FRAC;
    localparam logic signed [DIFF_W-1:0] ARG_MIN   = -ARG_MAX;
    localparam logic signed [PROD_W-1:0] PROD_HALF = PROD_W'(1) <<< (GAIN_FRAC - 1);

    logic signed [DRIVE_W-1:0]    in_drive;
    logic signed [DIFF_W-1:0]     diff;
    logic signed [DIFF_W-1:0]     half_rnd;
    logic signed [DIFF_W-1:0]     half;
    logic signed [ARG_W-1:0]      arg_next;
    logic signed [ARG_W-1:0]      arg_reg;
    logic signed [CUBE_OUT_W-1:0] clip;
    logic signed [PD_W-1:0]       pdiff;
    logic signed [GAIN_W:0]       gain_s;
    logic signed [PROD_W-1:0]     prod_next;
    logic signed [PROD_W-1:0]     prod_reg;
    logic signed [PROD_W-1:0]     prod_rnd;
    logic signed [PROD_W-1:0]     step;
    logic signed [SUM_W-1:0]      sum;
    logic signed [STAGE_W-1:0]    stage_next;
    logic signed [STAGE_W-1:0]    stage_reg;
    logic signed [DRIVE_W-1:0]    stage_ext;
    logic [PIPE_W-1:0]            pipe_reg;
    logic                         done_reg;

    // Argument: half the difference, saturated to +-4.
    assign in_drive = link_in.drive;
    assign diff     = DIFF_W'(in_drive) - DIFF_W'(stage_reg);
    assign half_rnd = diff + DIFF_W'(1);
    assign half     = half_rnd >>> 1;

    always_comb
    begin
        if (half > ARG_MAX)
        begin
            arg_next = ARG_MAX[ARG_W-1:0];
        end
        else if (half < ARG_MIN)
        begin
            arg_next = ARG_MIN[ARG_W-1:0];
        end
        else
        begin
            arg_next = half[ARG_W-1:0];
        end
    end

    // Soft clip of the argument.
    nll_cubic u_clip (
        .clk  (clk),
        .arg  (arg_reg),
        .clip (clip)
    );

    // Step product g * (target - state).
    assign gain_s    = $signed({1'b0, gain});
    assign pdiff     = PD_W'(clip) - PD_W'(stage_reg);
    assign prod_next = pdiff * gain_s;

    // New state, clipped to +-1.
    assign prod_rnd = prod_reg + PROD_HALF;
    assign step     = prod_rnd >>> GAIN_FRAC;
    assign sum      = SUM_W'(stage_reg) + $signed(step[SUM_W-1:0]);

    always_comb
    begin
        if (sum > SUM_W'(STAGE_ONE))
        begin
            stage_next = STAGE_ONE;
        end
        else if (sum < SUM_W'(STAGE_NEG_ONE))
        begin
            stage_next = STAGE_NEG_ONE;
        end
        else
        begin
            stage_next = sum[STAGE_W-1:0];
        end
    end

    // Progress marks, state and the done pulse.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pipe_reg  <= '0;
            done_reg  <= 1'b0;
            stage_reg <= '0;
        end
        else
        begin
            pipe_reg <= {pipe_reg[PIPE_W-2:0], link_in.go};
            done_reg <= pipe_reg[PIPE_W-1];
            if (pipe_reg[PIPE_W-1])
            begin
                stage_reg <= stage_next;
            end
        end
    end

    // Argument and product registers.
    always_ff @(posedge clk)
    begin
        if (link_in.go)
        begin
            arg_reg <= arg_next;
        end
        if (pipe_reg[CUBE_LAT])
        begin
            prod_reg <= prod_next;
        end
    end

    // The neighbor sees twice the updated state.
    assign stage_ext      = DRIVE_W'(stage_reg);
    assign link_out.go    = done_reg;
    assign link_out.drive = stage_ext <<< 1;
    assign stage          = stage_reg;

endmodule

FILE: hdl/nonlinear_ladder_lowpass.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nonlinear ladder lowpass
// Four-pole ladder lowpass with input drive, resonance feedback and a cubic
// soft clip in every stage and at the output.
//
// Channel   Direction  Signals                          Content
// s_*       in         s_tvalid s_tready s_tdata        sample_in
// m_*       out        m_tvalid m_tready m_tdata        sample_out
// APB       in/out     psel penable pwrite paddr ...    cutoff, resonance, drive
//
// After the accepting edge a request runs through the front steps (the products, their
// sum and the start pulse), then the four ladder cells in series, and then the output
// soft clip and the output register load, after which m_tvalid rises.
// Reset clears the stage states and loads the register defaults.
// A new request is taken once the previous result is in the output register;
// a stalled output holds the block in its last state until it is taken.
// ----------------------------------------------------------------------------
module nonlinear_ladder_lowpass #(
    parameter  int SAMPLE_BITS = nll_pkg::SAMPLE_BITS_DEF,
    localparam int TDATA_W     = ((SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [TDATA_W-1:0]                s_tdata,   // [SAMPLE_BITS-1:0] sample_in
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [TDATA_W-1:0]                m_tdata,   // [SAMPLE_BITS-1:0] sample_out
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [nll_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [nll_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [nll_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready
);
    import nll_pkg::*;

    localparam int X22_W   = STAGE_W + 1;
    localparam int FBD_W   = STAGE_W + 2;
    localparam int KW      = GAIN_W + 2;
    localparam int DPROD_W = X22_W + KW;
    localparam int FPROD_W = FBD_W + RES_W + 1;
    localparam int CNT_W   = $clog2(CUBE_LAT);

    localparam logic signed [DPROD_W-1:0] DPROD_HALF = DPROD_W'(1) <<< (PRE_SHIFT - 1);
    localparam logic signed [FPROD_W-1:0] FPROD_HALF = FPROD_W'(1) <<< (PRE_SHIFT - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_SUM,
        ST_START,
        ST_CHAIN,
        ST_OUTC,
        ST_DONE
    } state_t;

    state_t                        state_reg;
    state_t                        state_next;
    logic [CNT_W-1:0]              cnt_reg;
    logic [CNT_W-1:0]              cnt_next;
    logic                          m_valid_reg;
    logic                          m_valid_next;
    logic [TDATA_W-1:0]            m_data_reg;
    logic [TDATA_W-1:0]            m_data_next;

    logic [GAIN_W-1:0]             cutoff_gain_reg;
    logic [RES_W-1:0]              resonance_reg;
    logic [DRV_AMT_W-1:0]          drive_amount_reg;
    logic [GAIN_W-1:0]             gain_eff;
    logic                          cfg_write;

    logic                          accept;
    logic signed [SAMPLE_BITS-1:0] x_in;
    logic signed [X22_W-1:0]       x22;
    logic signed [X22_W-1:0]       x22_reg;
    logic [KW-1:0]                 kmul;
    logic signed [KW-1:0]          kmul_s;
    logic signed [RES_W:0]         res_s;
    logic signed [FBD_W-1:0]       s3_ext;
    logic signed [FBD_W-1:0]       fb_diff;
    logic signed [DPROD_W-1:0]     drv_prod_reg;
    logic signed [FPROD_W-1:0]     fb_prod_reg;
    logic signed [DPROD_W-1:0]     drv_rnd;
    logic signed [DPROD_W-1:0]     drv_shr;
    logic signed [FPROD_W-1:0]     fb_rnd;
    logic signed [FPROD_W-1:0]     fb_shr;
    logic signed [DRIVE_W-1:0]     d0_reg;

    nll_link_t                     link [NUM_STAGES+1];
    logic signed [STAGE_W-1:0]     stage_val [NUM_STAGES];
    logic [NUM_STAGES-1:0]         go_vec;
    logic signed [STAGE_W-1:0]     s3;
    logic signed [ARG_W-1:0]       out_arg;
    logic signed [CUBE_OUT_W-1:0]  out_clip;
    logic signed [SAMPLE_BITS-1:0] out_sample;

    // Configuration registers.
    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cutoff_gain_reg  <= CUTOFF_RESET;
            resonance_reg    <= RESONANCE_RESET;
            drive_amount_reg <= DRIVE_RESET;
        end
        else if (cfg_write)
        begin
            case (paddr[3:2])
                REG_CUTOFF:    cutoff_gain_reg  <= pwdata[GAIN_W-1:0];
                REG_RESONANCE: resonance_reg    <= pwdata[RES_W-1:0];
                REG_DRIVE:     drive_amount_reg <= pwdata[DRV_AMT_W-1:0];
                default:       ;
            endcase
        end
    end

    // Register read back.
    always_comb
    begin
        case (paddr[3:2])
            REG_CUTOFF:    prdata = APB_DATA_W'(cutoff_gain_reg);
            REG_RESONANCE: prdata = APB_DATA_W'(resonance_reg);
            REG_DRIVE:     prdata = APB_DATA_W'(drive_amount_reg);
            default:       prdata = '0;
        endcase
    end

    // Step gain limited to its usable range.
    always_comb
    begin
        if (cutoff_gain_reg < GAIN_MIN)
        begin
            gain_eff = GAIN_MIN;
        end
        else if (cutoff_gain_reg > GAIN_MAX)
        begin
            gain_eff = GAIN_MAX;
        end
        else
        begin
            gain_eff = cutoff_gain_reg;
        end
    end

    // Input sample to Q.22.
    assign x_in = s_tdata[SAMPLE_BITS-1:0];

    generate
        if (SAMPLE_BITS > STAGE_W)
        begin : g_in_down
            localparam int IN_SH = SAMPLE_BITS - STAGE_W;
            localparam int XE_W  = SAMPLE_BITS + 1;
            localparam logic signed [XE_W-1:0] XE_HALF = XE_W'(1) <<< (IN_SH - 1);
            logic signed [XE_W-1:0] xe;
            logic signed [XE_W-1:0] xr;
            logic signed [XE_W-1:0] xs;
            assign xe  = XE_W'(x_in);
            assign xr  = xe + XE_HALF;
            assign xs  = xr >>> IN_SH;
            assign x22 = xs[X22_W-1:0];
        end
        else if (SAMPLE_BITS == STAGE_W)
        begin : g_in_same
            assign x22 = X22_W'(x_in);
        end
        else
        begin : g_in_up
            localparam int IN_SH = STAGE_W - SAMPLE_BITS;
            logic signed [X22_W-1:0] xe;
            assign xe  = X22_W'(x_in);
            assign x22 = xe <<< IN_SH;
        end
    endgenerate

    // Front products: driven input and resonance feedback.
    assign kmul    = KW'(DRIVE_BASE) + (KW'(drive_amount_reg) << 1) + KW'(drive_amount_reg);
    assign kmul_s  = $signed(kmul);
    assign res_s   = $signed({1'b0, resonance_reg});
    assign s3      = stage_val[NUM_STAGES-1];
    assign s3_ext  = FBD_W'(s3);
    assign fb_diff = (s3_ext <<< 1) - FBD_W'(x22_reg);

    assign drv_rnd = drv_prod_reg + DPROD_HALF;
    assign drv_shr = drv_rnd >>> PRE_SHIFT;
    assign fb_rnd  = fb_prod_reg + FPROD_HALF;
    assign fb_shr  = fb_rnd >>> PRE_SHIFT;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            x22_reg <= x22;
        end
        if (state_reg == ST_MUL)
        begin
            drv_prod_reg <= x22_reg * kmul_s;
            fb_prod_reg  <= fb_diff * res_s;
        end
        if (state_reg == ST_SUM)
        begin
            d0_reg <= $signed(drv_shr[DRIVE_W-1:0]) + $signed(fb_shr[DRIVE_W-1:0]);
        end
    end

    // Row of ladder cells, each starting when its neighbor finishes.
    assign link[0].go    = (state_reg == ST_START);
    assign link[0].drive = d0_reg;

    generate
        for (genvar i = 0; i < NUM_STAGES; i++)
        begin : g_cell
            nll_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .gain     (gain_eff),
                .link_in  (link[i]),
                .link_out (link[i+1]),
                .stage    (stage_val[i])
            );
            assign go_vec[i] = link[i+1].go;
        end
    endgenerate

    // Output soft clip of the last stage.
    assign out_arg = ARG_W'(s3);

    nll_cubic u_out_clip (
        .clk  (clk),
        .arg  (out_arg),
        .clip (out_clip)
    );

    generate
        if (SAMPLE_BITS > STAGE_W)
        begin : g_out_up
            localparam int OUT_SH = SAMPLE_BITS - STAGE_W;
            logic signed [SAMPLE_BITS-1:0] oe;
            assign oe         = SAMPLE_BITS'(out_clip);
            assign out_sample = oe <<< OUT_SH;
        end
        else if (SAMPLE_BITS == STAGE_W)
        begin : g_out_same
            assign out_sample = out_clip[SAMPLE_BITS-1:0];
        end
        else
        begin : g_out_down
            localparam int OUT_SH = STAGE_W - SAMPLE_BITS;
            localparam logic signed [CUBE_OUT_W-1:0] OUT_HALF =
                CUBE_OUT_W'(1) <<< (OUT_SH - 1);
            logic signed [CUBE_OUT_W-1:0] orr;
            logic signed [CUBE_OUT_W-1:0] osh;
            assign orr        = out_clip + OUT_HALF;
            assign osh        = orr >>> OUT_SH;
            assign out_sample = osh[SAMPLE_BITS-1:0];
        end
    endgenerate

    // Sequencer and output register.
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (m_valid_reg && m_tready)
        begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:   state_next = ST_SUM;
            ST_SUM:   state_next = ST_START;
            ST_START: state_next = ST_CHAIN;
            ST_CHAIN:
            begin
                if (link[NUM_STAGES].go)
                begin
                    state_next = ST_OUTC;
                    cnt_next   = '0;
                end
            end
            ST_OUTC:
            begin
                if (cnt_reg == CNT_W'(CUBE_LAT - 1))
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_DONE:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = TDATA_W'($unsigned(out_sample));
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
            m_data_reg  <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
            m_data_reg  <= m_data_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

`ifndef ASSERT_OFF
    // Only one cell finishes at a time along the row.
    a_one_cell_done: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(go_vec))
        else $error("more than one ladder cell finished in the same cycle");

    // A new request enters the row only when no cell is finishing.
    a_row_idle_at_start: assert property (@(posedge clk) disable iff (!rst_n)
        link[0].go |-> (go_vec == '0))
        else $error("ladder row started while a cell was still working");

    // The last cell finishes only while the sequencer waits for it.
    a_last_done_in_chain: assert property (@(posedge clk) disable iff (!rst_n)
        link[NUM_STAGES].go |-> (state_reg == ST_CHAIN))
        else $error("last ladder cell finished outside the chain phase");

    // The last stage state stays within +-1.
    a_stage_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (s3 <= STAGE_ONE) && (s3 >= STAGE_NEG_ONE))
        else $error("last stage state left the range of +-1");
`endif

endmodule
